// ----- hdl/abdm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abdm_pkg
// Shared types and constants of the antialiased disc brush mask unit.
// ---------------------------------------------------------------------------
package abdm_pkg;

    localparam int BRUSH_SPAN = 199;

    // Register and lengths (lengths in 1/256 pixel units)
    localparam int WIDTH_BITS  = 12;
    localparam int RADIUS_BITS = 15;
    localparam int DIST_BITS   = 16;
    localparam int LEN_BITS    = 18;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 12'd16;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = 12'd16;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'((BRUSH_SPAN - 6) * 16);

    // Width thresholds of the border table (1/16 pixel units)
    localparam logic [WIDTH_BITS-1:0] WIDTH_3P0  = 12'd96;
    localparam logic [WIDTH_BITS-1:0] WIDTH_2P5  = 12'd80;
    localparam logic [WIDTH_BITS-1:0] WIDTH_2P0  = 12'd64;
    localparam logic [WIDTH_BITS-1:0] WIDTH_1P25 = 12'd40;
    localparam logic [WIDTH_BITS-1:0] WIDTH_0P75 = 12'd24;

    // Border codes
    localparam logic [1:0] BORDER_0P50 = 2'd0;
    localparam logic [1:0] BORDER_0P75 = 2'd1;
    localparam logic [1:0] BORDER_1P00 = 2'd2;
    localparam logic [1:0] BORDER_1P25 = 2'd3;

    // Coverage levels and ramp spans
    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] LEVEL_HIGH = 8'd176;
    localparam logic [7:0] LEVEL_LOW  = 8'd32;
    localparam logic [7:0] LEVEL_NONE = 8'd0;
    localparam logic [7:0] SPAN_INNER = LEVEL_FULL - LEVEL_HIGH;
    localparam logic [7:0] SPAN_OUTER = LEVEL_HIGH - LEVEL_LOW;
    localparam logic [7:0] SPAN_OUTER2 = LEVEL_LOW;

    // Reciprocals for division by 3 and 5 of values below 1024
    localparam logic [9:0] RECIP_3 = 10'd683;
    localparam int         RECIP_3_SHIFT = 11;
    localparam logic [7:0] RECIP_5 = 8'd205;
    localparam int         RECIP_5_SHIFT = 10;

    // Square root pipeline split
    localparam int ROOT_STAGES     = 4;
    localparam int ROOT_STEPS      = DIST_BITS / ROOT_STAGES;
    localparam int REM_BITS        = DIST_BITS + 1;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [DIST_BITS-1:0] root;
        logic [DIST_BITS-1:0] rad;
    } root_t;

    function automatic logic [LEN_BITS-1:0] border_len(input logic [1:0] code);
        logic [LEN_BITS-1:0] len;
        unique case (code)
            BORDER_0P50: len = 18'd128;
            BORDER_0P75: len = 18'd192;
            BORDER_1P00: len = 18'd256;
            default:     len = 18'd320;
        endcase
        return len;
    endfunction

endpackage

// ----- hdl/abdm_root_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abdm_root_stage
// One registered slice of the digit-by-digit square root: a few result
// bits per stage, two radicand bits consumed per step.
// ---------------------------------------------------------------------------
module abdm_root_stage
    import abdm_pkg::*;
(
    input  logic  aclk,
    input  logic  load,
    input  root_t d_in,
    output root_t q_out
);

    root_t                stage_next;
    root_t                q_reg;

    always_comb begin
        logic [REM_BITS+1:0] cur;
        logic [REM_BITS+1:0] trial;
        stage_next = d_in;
        for (int i = 0; i < ROOT_STEPS; i++) begin
            cur   = {stage_next.rem, stage_next.rad[DIST_BITS-1 -: 2]};
            trial = {1'b0, stage_next.root, 2'b01};
            stage_next.rad = {stage_next.rad[DIST_BITS-3:0], 2'b00};
            if (cur >= trial) begin
                cur             = cur - trial;
                stage_next.rem  = cur[REM_BITS-1:0];
                stage_next.root = {stage_next.root[DIST_BITS-2:0], 1'b1};
            end else begin
                stage_next.rem  = cur[REM_BITS-1:0];
                stage_next.root = {stage_next.root[DIST_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= stage_next;
        end
    end

    assign q_out = q_reg;

endmodule

// ----- hdl/antialiased_disc_brush_mask_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// antialiased_disc_brush_mask_unit
// Coverage of one mask pixel of an antialiased round brush.
// ---------------------------------------------------------------------------
// Accepts one pixel offset per clock when the output side keeps up and
// returns its coverage. The first stage squares and sums the offsets, the
// root stages run the 16-step integer square root (four result bits per
// stage), the next stage picks the ramp and scales the distance, and the
// last divides by the border width and adds the ramp base. Every stage
// holds its own valid bit, so a stall on the result side lets bubbles close
// up and drops nothing. The brush width register may be written only while
// no pixel is in flight; its clamp and border table act directly on it.
// ---------------------------------------------------------------------------
module antialiased_disc_brush_mask_unit
    import abdm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [WIDTH_BITS-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [7:0]     s_offset_x,
    input  logic signed [7:0]     s_offset_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_coverage
);

    localparam int NSTAGES = ROOT_STAGES + 3;

    logic [WIDTH_BITS-1:0] brush_width_reg;
    logic [NSTAGES-1:0]    valid_reg;
    logic [NSTAGES-1:0]    valid_next;
    logic [NSTAGES-1:0]    adv;

    // ---- configuration ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brush_width_reg <= WIDTH_RESET;
        end else if (cfg_we) begin
            brush_width_reg <= cfg_wdata;
        end
    end

    logic [WIDTH_BITS-1:0]  width_clamped;
    logic [RADIUS_BITS-1:0] radius;
    logic [1:0]             inner_code, outer_code, outer2_code;

    always_comb begin
        if (brush_width_reg < WIDTH_MIN) begin
            width_clamped = WIDTH_MIN;
        end else if (brush_width_reg > WIDTH_MAX) begin
            width_clamped = WIDTH_MAX;
        end else begin
            width_clamped = brush_width_reg;
        end
        radius = {width_clamped, 3'b000};

        if (width_clamped >= WIDTH_3P0) begin
            inner_code = BORDER_1P00; outer_code = BORDER_1P00; outer2_code = BORDER_1P00;
        end else if (width_clamped >= WIDTH_2P5) begin
            inner_code = BORDER_0P75; outer_code = BORDER_1P00; outer2_code = BORDER_1P25;
        end else if (width_clamped >= WIDTH_2P0) begin
            inner_code = BORDER_0P75; outer_code = BORDER_1P00; outer2_code = BORDER_1P00;
        end else if (width_clamped >= WIDTH_1P25) begin
            inner_code = BORDER_0P75; outer_code = BORDER_0P75; outer2_code = BORDER_1P00;
        end else if (width_clamped >= WIDTH_0P75) begin
            inner_code = BORDER_0P50; outer_code = BORDER_0P75; outer2_code = BORDER_1P00;
        end else begin
            inner_code = BORDER_0P50; outer_code = BORDER_0P75; outer2_code = BORDER_0P75;
        end
    end

    // ---- flow control: a stage advances when it is empty or its successor moves ----
    always_comb begin
        adv[NSTAGES-1] = !valid_reg[NSTAGES-1] || m_ready;
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTAGES; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NSTAGES-1];

    // ---- stage 1: squared distance ----
    logic [7:0]  mag_x, mag_y;
    logic [15:0] sq_sum_next;
    logic [15:0] sq_sum_reg;

    always_comb begin
        mag_x       = s_offset_x[7] ? (~s_offset_x + 8'd1) : s_offset_x;
        mag_y       = s_offset_y[7] ? (~s_offset_y + 8'd1) : s_offset_y;
        sq_sum_next = (mag_x * mag_x) + (mag_y * mag_y);
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            sq_sum_reg <= sq_sum_next;
        end
    end

    // ---- stages 2..5: square root of sq_sum * 65536 ----
    root_t root_chain [ROOT_STAGES+1];

    assign root_chain[0] = '{rem: '0, root: '0, rad: sq_sum_reg};

    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
        abdm_root_stage u_stage (
            .aclk  (aclk),
            .load  (adv[g+1]),
            .d_in  (root_chain[g]),
            .q_out (root_chain[g+1])
        );
    end

    // ---- stage 6: ramp select and scaling ----
    logic [LEN_BITS-1:0] dist_len, rad_len, len_in, len_out, len_out2;
    logic [LEN_BITS-1:0] edge_full, edge_out, edge_out2, diff;
    logic [7:0]          span_sel, base_next;
    logic [1:0]          div_next;
    logic [16:0]         prod;
    logic [16:0]         num_next;
    logic [16:0]         num_reg;
    logic [1:0]          div_reg;
    logic [7:0]          base_reg;

    always_comb begin
        dist_len  = {2'b00, root_chain[ROOT_STAGES].root};
        rad_len   = {3'b000, radius};
        len_in    = border_len(inner_code);
        len_out   = border_len(outer_code);
        len_out2  = border_len(outer2_code);
        edge_full = dist_len + len_in;
        edge_out  = rad_len + len_out;
        edge_out2 = edge_out + len_out2;
        diff      = '0;
        span_sel  = 8'd0;
        div_next  = BORDER_1P00;
        base_next = LEVEL_NONE;
        if (edge_full <= rad_len) begin
            base_next = LEVEL_FULL;
        end else if (dist_len < rad_len) begin
            diff      = rad_len - dist_len;
            span_sel  = SPAN_INNER;
            div_next  = inner_code;
            base_next = LEVEL_HIGH;
        end else if (dist_len < edge_out) begin
            diff      = edge_out - dist_len;
            span_sel  = SPAN_OUTER;
            div_next  = outer_code;
            base_next = LEVEL_LOW;
        end else if (dist_len < edge_out2) begin
            diff      = edge_out2 - dist_len;
            span_sel  = SPAN_OUTER2;
            div_next  = outer2_code;
            base_next = LEVEL_NONE;
        end
        // diff never exceeds one border width here
        prod     = diff[8:0] * span_sel;
        num_next = prod;
    end

    always_ff @(posedge aclk) begin
        if (adv[NSTAGES-2]) begin
            num_reg  <= num_next;
            div_reg  <= div_next;
            base_reg <= base_next;
        end
    end

    // ---- stage 7: divide by the border width, add the ramp base ----
    logic [10:0] quot64;
    logic [20:0] prod3;
    logic [18:0] prod5;
    logic [7:0]  quot;
    logic [7:0]  coverage_next;
    logic [7:0]  coverage_reg;

    always_comb begin
        quot64 = num_reg[16:6];
        prod3  = quot64 * RECIP_3;
        prod5  = quot64 * RECIP_5;
        case (div_reg)
            BORDER_0P50: quot = quot64[8:1];
            BORDER_0P75: quot = prod3[RECIP_3_SHIFT +: 8];
            BORDER_1P00: quot = quot64[9:2];
            default:     quot = prod5[RECIP_5_SHIFT +: 8];
        endcase
        coverage_next = base_reg + quot;
    end

    always_ff @(posedge aclk) begin
        if (adv[NSTAGES-1]) begin
            coverage_reg <= coverage_next;
        end
    end

    assign m_coverage = coverage_reg;

endmodule

// ----- tb/antialiased_disc_brush_mask_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// antialiased_disc_brush_mask_unit_tb
// Self-checking bench for the antialiased disc brush coverage unit.
// ---------------------------------------------------------------------------
// Drives pixel offsets through the valid/ready input channel and checks every
// coverage transfer against a bit-exact model of the disc ramps, kept in a
// small scoreboard class. A short directed set covers the offset extremes and
// the two outer ramps at the reset width; then the brush width register is swept
// through every border table threshold, both clamp limits and random values,
// with offsets biased toward the brush edge. Both channels stall in random
// bursts except near the end of the run.
// ---------------------------------------------------------------------------
module antialiased_disc_brush_mask_unit_tb;
    import abdm_pkg::*;

    localparam int unsigned LEN_HALF         = 128;
    localparam int unsigned LEN_THREE_FOURTH = 192;
    localparam int unsigned LEN_ONE          = 256;
    localparam int unsigned LEN_FIVE_FOURTH  = 320;

    localparam int RANDOM_PHASES    = 20;
    localparam int ITEMS_PER_PHASE  = 90;
    localparam int CALM_TAIL_ITEMS  = 200;
    localparam int DRAIN_CYCLES     = 12;

    // -----------------------------------------------------------------------
    // Scoreboard: holds the brush width and the queue of expected coverage
    // -----------------------------------------------------------------------
    class coverage_scoreboard;
        logic [WIDTH_BITS-1:0] width_reg;
        logic [7:0]            coverage_q[$];
        int                    mismatches;
        int                    checked;

        function new();
            width_reg  = WIDTH_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_width(input logic [WIDTH_BITS-1:0] w);
            width_reg = w;
        endfunction

        function int pending();
            return coverage_q.size();
        endfunction

        function int unsigned clamped_width();
            int unsigned w;
            w = width_reg;
            if (w < WIDTH_MIN)
                w = WIDTH_MIN;
            else if (w > WIDTH_MAX)
                w = WIDTH_MAX;
            return w;
        endfunction

        function logic [7:0] disc_coverage(input logic signed [7:0] ox,
                                           input logic signed [7:0] oy);
            logic [8:0]      ax;
            logic [8:0]      ay;
            longint unsigned dist_sq;
            logic [15:0]     dist_root;
            logic [15:0]     cand;
            int unsigned     w;
            int unsigned     r;
            int unsigned     d;
            int unsigned     bi;
            int unsigned     bo;
            int unsigned     bo2;
            int unsigned     cov;

            // magnitude as 9 bits so that -128 maps to 128
            ax = ox[7] ? (9'd256 - {1'b0, ox}) : {1'b0, ox};
            ay = oy[7] ? (9'd256 - {1'b0, oy}) : {1'b0, oy};
            dist_sq = (64'(ax) * 64'(ax) + 64'(ay) * 64'(ay)) << 16;

            // integer square root, one result bit per pass
            dist_root = '0;
            for (int b = 15; b >= 0; b--) begin
                cand = dist_root | (16'd1 << b);
                if (64'(cand) * 64'(cand) <= dist_sq)
                    dist_root = cand;
            end
            d = dist_root;

            w = clamped_width();
            r = w * 8;
            if (w >= WIDTH_3P0) begin
                bi = LEN_ONE; bo = LEN_ONE; bo2 = LEN_ONE;
            end else if (w >= WIDTH_2P5) begin
                bi = LEN_THREE_FOURTH; bo = LEN_ONE; bo2 = LEN_FIVE_FOURTH;
            end else if (w >= WIDTH_2P0) begin
                bi = LEN_THREE_FOURTH; bo = LEN_ONE; bo2 = LEN_ONE;
            end else if (w >= WIDTH_1P25) begin
                bi = LEN_THREE_FOURTH; bo = LEN_THREE_FOURTH; bo2 = LEN_ONE;
            end else if (w >= WIDTH_0P75) begin
                bi = LEN_HALF; bo = LEN_THREE_FOURTH; bo2 = LEN_ONE;
            end else begin
                bi = LEN_HALF; bo = LEN_THREE_FOURTH; bo2 = LEN_THREE_FOURTH;
            end

            if (d + bi <= r)
                cov = LEVEL_FULL;
            else if (d < r)
                cov = LEVEL_HIGH + ((r - d) * 32'(SPAN_INNER)) / bi;
            else if (d < r + bo)
                cov = LEVEL_LOW + ((r + bo - d) * 32'(SPAN_OUTER)) / bo;
            else if (d < r + bo + bo2)
                cov = ((r + bo + bo2 - d) * 32'(SPAN_OUTER2)) / bo2;
            else
                cov = LEVEL_NONE;
            return 8'(cov);
        endfunction

        function void note_offset(input logic signed [7:0] ox,
                                  input logic signed [7:0] oy);
            coverage_q.push_back(disc_coverage(ox, oy));
        endfunction

        function void check_coverage(input logic [7:0] got);
            logic [7:0] want;
            if (coverage_q.size() == 0) begin
                $error("coverage: unexpected transfer, expected none, actual %0d", got);
                mismatches++;
                return;
            end
            want = coverage_q.pop_front();
            checked++;
            if (got !== want) begin
                $error("coverage: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT and clock
    // -----------------------------------------------------------------------
    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [WIDTH_BITS-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [7:0]     s_offset_x;
    logic signed [7:0]     s_offset_y;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_coverage;

    coverage_scoreboard sb;
    bit                 calm_tail;
    int                 offsets_sent;
    int                 width_settings;

    antialiased_disc_brush_mask_unit u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_offset_x (s_offset_x),
        .s_offset_y (s_offset_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_coverage (m_coverage)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    task automatic send_offset(input logic signed [7:0] ox,
                               input logic signed [7:0] oy);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_offset_x <= ox;
        s_offset_y <= oy;
        do @(posedge aclk); while (!s_ready);
        sb.note_offset(ox, oy);
        offsets_sent++;
    endtask

    task automatic write_width(input logic [WIDTH_BITS-1:0] w);
        // only touch the register once the pipeline has drained
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_width(w);
        width_settings++;
    endtask

    function automatic logic signed [7:0] pick_axis(input int reach);
        int mag;
        mag = $urandom_range(0, reach);
        return ($urandom_range(0, 1) == 1) ? 8'(-mag) : 8'(mag);
    endfunction

    task automatic send_random_offset();
        int reach;
        int mode;
        reach = sb.clamped_width() / 32 + 4;
        if (reach > 99)
            reach = 99;
        mode = $urandom_range(0, 19);
        if (mode < 14)
            send_offset(pick_axis(reach), pick_axis(reach));
        else if (mode < 19)
            send_offset(pick_axis(99), pick_axis(99));
        else
            send_offset(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // result side: stall in bursts, hold ready high in the calm tail
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm_tail && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_coverage(m_coverage);
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        logic [WIDTH_BITS-1:0] sweep[$];
        logic signed [7:0]     edge_x[$];
        logic signed [7:0]     edge_y[$];
        int                    total_random;

        sb             = new();
        calm_tail      = 1'b0;
        offsets_sent   = 0;
        width_settings = 0;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_offset_x     = '0;
        s_offset_y     = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed set at the reset width: centre, ramp neighbours, extremes
        edge_x = '{0, 1, 0, -1, 0, 1, -1, 2, 0, 99, -99, 99, -99, 0,
                   -128, 127, -128, 127, -128, 3, -5};
        edge_y = '{0, 0, 1, 0, -1, 1, -1, 0, -2, 99, -99, -99, 0, 99,
                   -128, 127, 127, -128, 0, 4, 12};
        foreach (edge_x[i])
            send_offset(edge_x[i], edge_y[i]);
        s_valid <= 1'b0;

        // table thresholds on both sides, both clamp limits, then random
        sweep = '{12'd0, 12'd15, 12'd16, 12'd23, 12'd24, 12'd39, 12'd40,
                  12'd63, 12'd64, 12'd79, 12'd80, 12'd95, 12'd96, 12'd1600,
                  12'd3088, 12'd3089, 12'd4095};
        while (sweep.size() < RANDOM_PHASES)
            sweep.push_back(WIDTH_BITS'($urandom_range(0, 4095)));

        total_random = RANDOM_PHASES * ITEMS_PER_PHASE;
        foreach (sweep[p]) begin
            write_width(sweep[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p * ITEMS_PER_PHASE + n >= total_random - CALM_TAIL_ITEMS)
                    calm_tail = 1'b1;
                send_random_offset();
            end
            s_valid <= 1'b0;
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d pixel offsets across %0d brush width settings;",
                 offsets_sent, width_settings);
        $display("checked %0d coverage transfers with random stalls on both sides.",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("antialiased_disc_brush_mask_unit verification clean");
        else
            $display("antialiased_disc_brush_mask_unit verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d coverage transfers outstanding", sb.pending());
        $display("antialiased_disc_brush_mask_unit verification failed");
        $finish;
    end

endmodule
